// ===== design/tcfifo_pkg.sv =====
// Package for the two-class oldest-first FIFO.
// Request and status codes, plus the control/status structs shared by the queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tcfifo_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ_ANY = 2'd1,
    REQ_DEQ_C1  = 2'd2,
    REQ_DEQ_C0  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-queue commands from the top level
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  // per-queue occupancy flags back to the top level
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ===== design/tcfifo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcfifo_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/tcfifo_queue.sv =====
// One class queue: head/tail pointers, occupancy count, entry RAM and head look-ahead.
// Depends on tcfifo_pkg and tcfifo_ram.
`timescale 1ns / 1ps

module tcfifo_queue
  import tcfifo_pkg::*;
#(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_ctl_t  ctl,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] head_data,
  output queue_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [WIDTH-1:0] rd_data;
  logic             bypass_hit;
  logic [WIDTH-1:0] bypass_data;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_next  = ctl.pop  ? wrap_inc(head) : head;
    tail_next  = ctl.push ? wrap_inc(tail) : tail;
    count_next = count;
    if (ctl.push && !ctl.pop) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      bypass_hit <= 1'b0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      // write landing on the address being read: forward it past the RAM
      bypass_hit <= ctl.push && (tail == head_next);
    end
    bypass_data <= wr_data;
  end

  // read address follows the next head, so the head word is ready every cycle
  tcfifo_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  assign head_data  = bypass_hit ? bypass_data : rd_data;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

endmodule

// ===== design/two_class_fifo_oldest_first.sv =====
// Two-class FIFO with global oldest-first dequeue.
// Result word: registered on m_* and shown in the cycle after the request is accepted.
// Throughput: one request per cycle while m_tready is high; a result word left waiting holds
// s_tready low, so the single output register sets the rate.
// Reset: pointers, counts, sequence counter and output valid cleared; entry RAMs are not cleared.
// Depends on tcfifo_pkg and tcfifo_queue.
`timescale 1ns / 1ps

module two_class_fifo_oldest_first
  import tcfifo_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int SEQ_BITS    = 8
) (
  input  logic clk,
  input  logic rst,
  // request side
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [ID_BITS-1:0] item_id, [ID_BITS] item_class, zero pad above
  input  logic [((ID_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]                         s_tuser,
  // result side
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [ID_BITS-1:0] out_id, [ID_BITS] out_class, zero pad above
  output logic [((ID_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // [1:0] status
  output logic [1:0]                         m_tuser
);

  localparam int DATA_W  = ((ID_BITS + 1 + 7) / 8) * 8;
  localparam int ENTRY_W = SEQ_BITS + ID_BITS;

  // request decode
  logic               s_fire;
  req_t               req;
  logic [ID_BITS-1:0] item_id;
  logic               item_class;

  // queue interface
  queue_ctl_t         q0_ctl, q1_ctl;
  queue_stat_t        q0_stat, q1_stat;
  logic [ENTRY_W-1:0] q0_head, q1_head;
  logic [ENTRY_W-1:0] wr_entry;

  // shared arrival counter
  logic [SEQ_BITS-1:0] arrival_seq, arrival_seq_next;
  logic [SEQ_BITS-1:0] seq_diff;
  logic                c1_older;

  // result register
  status_t             status, status_next;
  logic [ID_BITS-1:0]  out_id, out_id_next;
  logic                out_class, out_class_next;

  // output register frees as soon as its word is taken
  assign s_tready   = !m_tvalid || m_tready;
  assign s_fire     = s_tvalid && s_tready;
  assign req        = req_t'(s_tuser);
  assign item_id    = s_tdata[ID_BITS-1:0];
  assign item_class = s_tdata[ID_BITS];
  assign wr_entry   = {arrival_seq, item_id};

  // class 1 head is older when seq0 - seq1 is nonzero and in the lower half-range
  assign seq_diff = q0_head[ENTRY_W-1 -: SEQ_BITS] - q1_head[ENTRY_W-1 -: SEQ_BITS];
  assign c1_older = (seq_diff != '0) && !seq_diff[SEQ_BITS-1];

  always_comb begin
    q0_ctl           = '0;
    q1_ctl           = '0;
    arrival_seq_next = arrival_seq;
    status_next      = ST_OK;
    out_id_next      = '0;
    out_class_next   = 1'b0;
    if (s_fire) begin
      unique case (req)
        REQ_ENQ: begin
          if (item_class ? q1_stat.full : q0_stat.full) begin
            status_next = ST_FULL;
          end else begin
            q0_ctl.push      = !item_class;
            q1_ctl.push      = item_class;
            arrival_seq_next = arrival_seq + SEQ_BITS'(1);
          end
        end
        REQ_DEQ_ANY: begin
          if (q0_stat.empty && q1_stat.empty) begin
            status_next = ST_EMPTY;
          end else if (q0_stat.empty || (!q1_stat.empty && c1_older)) begin
            q1_ctl.pop     = 1'b1;
            out_id_next    = q1_head[ID_BITS-1:0];
            out_class_next = 1'b1;
          end else begin
            q0_ctl.pop  = 1'b1;
            out_id_next = q0_head[ID_BITS-1:0];
          end
        end
        REQ_DEQ_C1: begin
          if (q1_stat.empty) begin
            status_next = ST_EMPTY;
          end else begin
            q1_ctl.pop     = 1'b1;
            out_id_next    = q1_head[ID_BITS-1:0];
            out_class_next = 1'b1;
          end
        end
        REQ_DEQ_C0: begin
          if (q0_stat.empty) begin
            status_next = ST_EMPTY;
          end else begin
            q0_ctl.pop  = 1'b1;
            out_id_next = q0_head[ID_BITS-1:0];
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_seq <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      arrival_seq <= arrival_seq_next;
      if (s_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_fire) begin
      status    <= status_next;
      out_id    <= out_id_next;
      out_class <= out_class_next;
    end
  end

  assign m_tuser = status;
  assign m_tdata = DATA_W'({out_class, out_id});

  tcfifo_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_q0 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q0_ctl),
    .wr_data   (wr_entry),
    .head_data (q0_head),
    .stat      (q0_stat)
  );

  tcfifo_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_q1 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q1_ctl),
    .wr_data   (wr_entry),
    .head_data (q1_head),
    .stat      (q1_stat)
  );

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (q0_ctl.pop |-> !q0_stat.empty) and (q1_ctl.pop |-> !q1_stat.empty))
    else $error("pop issued to empty queue");

  // no push into a full queue
  a_push_nonfull: assert property (@(posedge clk) disable iff (rst)
    (q0_ctl.push |-> !q0_stat.full) and (q1_ctl.push |-> !q1_stat.full))
    else $error("push issued to full queue");

  // sequence counter moves only on an accepted push
  a_seq_hold: assert property (@(posedge clk) disable iff (rst)
    !(q0_ctl.push || q1_ctl.push) |=> arrival_seq == $past(arrival_seq))
    else $error("arrival counter moved without a push");

  // empty or full result carries no item
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL)) |-> (m_tdata == '0))
    else $error("non-ok result carries item data");

endmodule

// ===== dv/tcfifo_order_check.sv =====
// Checker for the two-class oldest-first FIFO: watches both stream channels,
// keeps its own copy of the two class queues and compares every result word.
// Depends on tcfifo_pkg.
`timescale 1ns / 1ps

module tcfifo_order_check
  import tcfifo_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int SEQ_BITS    = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic                                     s_tvalid,
  input  logic                                     s_tready,
  input  logic [((ID_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic [1:0]                               s_tuser,
  input  logic                                     m_tvalid,
  input  logic                                     m_tready,
  input  logic [((ID_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic [1:0]                               m_tuser,
  output int errors,
  output int pending,
  output int n_results,
  output int n_empty,
  output int n_full,
  output int n_any_c1
);

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [SEQ_BITS-1:0] seq;
  } slot_t;

  typedef struct packed {
    status_t            status;
    logic [ID_BITS-1:0] id;
    logic               cls;
  } word_t;

  slot_t class0_slots[$];
  slot_t class1_slots[$];
  word_t due_words[$];
  logic [SEQ_BITS-1:0] arrival_seq;
  int err_count, result_count, empty_count, full_count, any_c1_count;

  // class 1 head wins when seq0 - seq1 (mod 2^SEQ_BITS) is nonzero and under half range
  function automatic logic class1_head_older();
    logic [SEQ_BITS-1:0] d;
    d = class0_slots[0].seq - class1_slots[0].seq;
    return (d != '0) && (d < (1 << (SEQ_BITS - 1)));
  endfunction

  task automatic serve_request(input req_t req, input logic [ID_BITS-1:0] id,
                               input logic cls);
    word_t w;
    slot_t s;
    int pick;
    w.status = ST_OK;
    w.id     = '0;
    w.cls    = 1'b0;
    pick     = -1;
    case (req)
      REQ_ENQ: begin
        s = {id, arrival_seq};
        if (cls && class1_slots.size() < QUEUE_DEPTH) begin
          class1_slots.push_back(s);
          arrival_seq = arrival_seq + 1'b1;
        end else if (!cls && class0_slots.size() < QUEUE_DEPTH) begin
          class0_slots.push_back(s);
          arrival_seq = arrival_seq + 1'b1;
        end else begin
          // dropped: the sequence counter holds
          w.status = ST_FULL;
          full_count++;
        end
      end
      REQ_DEQ_ANY: begin
        if (class0_slots.size() == 0 && class1_slots.size() == 0) pick = -1;
        else if (class0_slots.size() == 0) pick = 1;
        else if (class1_slots.size() == 0) pick = 0;
        else pick = class1_head_older() ? 1 : 0;
        if (pick == 1) any_c1_count++;
      end
      REQ_DEQ_C1: pick = (class1_slots.size() != 0) ? 1 : -1;
      default:    pick = (class0_slots.size() != 0) ? 0 : -1;
    endcase
    if (req != REQ_ENQ) begin
      if (pick < 0) begin
        w.status = ST_EMPTY;
        empty_count++;
      end else if (pick == 1) begin
        s     = class1_slots.pop_front();
        w.id  = s.id;
        w.cls = 1'b1;
      end else begin
        s    = class0_slots.pop_front();
        w.id = s.id;
      end
    end
    due_words.push_back(w);
  endtask

  always @(posedge clk) begin
    word_t oldest;
    if (rst) begin
      class0_slots.delete();
      class1_slots.delete();
      due_words.delete();
      arrival_seq  = '0;
      err_count    = 0;
      result_count = 0;
      empty_count  = 0;
      full_count   = 0;
      any_c1_count = 0;
    end else begin
      // request first, so a same-edge result still meets the oldest expectation
      if (s_tvalid && s_tready)
        serve_request(req_t'(s_tuser), s_tdata[ID_BITS-1:0], s_tdata[ID_BITS]);
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          err_count++;
          $display("%0t: result word with none expected: status %0d id %h class %0d",
                   $time, m_tuser, m_tdata[ID_BITS-1:0], m_tdata[ID_BITS]);
        end else begin
          oldest = due_words.pop_front();
          result_count++;
          if (m_tuser !== oldest.status) begin
            err_count++;
            $display("%0t: status expected %0d, got %0d", $time, oldest.status, m_tuser);
          end
          if (m_tdata[ID_BITS-1:0] !== oldest.id) begin
            err_count++;
            $display("%0t: out_id expected %h, got %h", $time, oldest.id,
                     m_tdata[ID_BITS-1:0]);
          end
          if (m_tdata[ID_BITS] !== oldest.cls) begin
            err_count++;
            $display("%0t: out_class expected %0d, got %0d", $time, oldest.cls,
                     m_tdata[ID_BITS]);
          end
        end
      end
    end
    errors    <= err_count;
    pending   <= due_words.size();
    n_results <= result_count;
    n_empty   <= empty_count;
    n_full    <= full_count;
    n_any_c1  <= any_c1_count;
  end

endmodule

// ===== dv/two_class_fifo_oldest_first_tb.sv =====
// Testbench top for two_class_fifo_oldest_first: makes request and stall
// stimulus and gives the verdict; checking lives in tcfifo_order_check.
// Depends on tcfifo_pkg, the block and tcfifo_order_check.
`timescale 1ns / 1ps

module two_class_fifo_oldest_first_tb;
  import tcfifo_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 16;
  localparam int SEQ_BITS     = 8;
  localparam int DATA_W       = ((ID_BITS + 1 + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 1025;
  localparam int QUIET_TAIL   = 120;  // last stretch runs with no idling
  localparam int STALL_LIMIT  = 1000; // cycles with no word moved before giving up

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side: tdata = {pad, item_class, item_id}, tuser = req_type
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic [1:0]        s_tuser  = REQ_ENQ;
  // result side: tdata = {pad, out_class, out_id}, tuser = status
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;

  int errors, pending, n_results, n_empty, n_full, n_any_c1;
  int n_enq, n_deq;
  int quiet_cycles;
  int stall_left;
  bit idle_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_class_fifo_oldest_first #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .SEQ_BITS   (SEQ_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  tcfifo_order_check #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .SEQ_BITS   (SEQ_BITS)
  ) i_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending),
    .n_results(n_results),
    .n_empty  (n_empty),
    .n_full   (n_full),
    .n_any_c1 (n_any_c1)
  );

  // Result-side back-pressure: stall bursts of random length while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("two_class_fifo_oldest_first: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request word and returns at the edge where it is taken.
  // tready is looked at on the falling edge, where it is settled.
  task automatic send_request(input req_t req, input logic [ID_BITS-1:0] id,
                              input logic cls);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= DATA_W'({cls, id});
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (req == REQ_ENQ) n_enq++;
    else n_deq++;
  endtask

  function automatic logic [ID_BITS-1:0] any_id();
    return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
  endfunction

  initial begin
    int left, seg_len, enq_pct, class_mode, r;
    req_t req;
    logic cls;

    n_enq   = 0;
    n_deq   = 0;
    idle_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every dequeue kind on an empty block
    send_request(REQ_DEQ_ANY, any_id(), 1'b1);
    send_request(REQ_DEQ_C0, any_id(), 1'b0);
    send_request(REQ_DEQ_C1, any_id(), 1'b1);
    // id extremes; class 1 arrives first so dequeue-any must pick it
    send_request(REQ_ENQ, {ID_BITS{1'b1}}, 1'b1);
    send_request(REQ_ENQ, '0, 1'b0);
    send_request(REQ_DEQ_ANY, '0, 1'b0);
    send_request(REQ_DEQ_C0, {ID_BITS{1'b1}}, 1'b1);
    // fill class 1 to the brim, one more is dropped, then dequeue-any with class 0 empty
    repeat (QUEUE_DEPTH + 1) send_request(REQ_ENQ, any_id(), 1'b1);
    send_request(REQ_DEQ_ANY, any_id(), 1'b0);

    // Random: segments pick at random among fill-heavy, balanced and drain-heavy traffic,
    // some leaning on one class so the two heads drift far apart in age.
    left = RANDOM_WORDS;
    while (left > 0) begin
      seg_len    = $urandom_range(20, 60);
      r          = $urandom_range(0, 2);
      enq_pct    = (r == 0) ? 25 : (r == 1) ? 50 : 80;
      class_mode = $urandom_range(0, 3);
      idle_on    = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < seg_len && left > 0; i++) begin
        if (left <= QUIET_TAIL) idle_on = 1'b0;
        case (class_mode)
          1:       cls = ($urandom_range(0, 9) == 0);
          2:       cls = ($urandom_range(0, 9) != 0);
          default: cls = 1'($urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 99) < enq_pct) begin
          req = REQ_ENQ;
        end else if (class_mode == 2 && $urandom_range(0, 3) != 0) begin
          // churn class 1 while class 0's head ages
          req = REQ_DEQ_C1;
        end else begin
          r   = $urandom_range(0, 9);
          req = (r < 4) ? REQ_DEQ_ANY : (r < 7) ? REQ_DEQ_C1 : REQ_DEQ_C0;
        end
        send_request(req, any_id(), cls);
        left--;
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d requests (%0d enqueues, %0d dequeues), %0d result words checked",
             n_enq + n_deq, n_enq, n_deq, n_results);
    $display("%0d dropped on full, %0d empty dequeues, %0d dequeue-any served class 1",
             n_full, n_empty, n_any_c1);
    if (errors == 0 && pending == 0) begin
      $display("two_class_fifo_oldest_first: match");
    end else begin
      $display("two_class_fifo_oldest_first: mismatch");
    end
    $finish;
  end

endmodule
